// File: sv/tsn_pkg.sv
// shared types and constants for the top-four score selection block
package tsn_pkg;

    localparam int SCORE_W   = 15;              // magnitude of a positive q8.8 score
    localparam int CLASS_W   = 8;
    localparam int WEIGHT_W  = 16;
    localparam int RANK_W    = 2;
    localparam int NUM_W     = 2 * SCORE_W + 1; // score * 2^15 plus half the sum
    localparam int QUO_W     = 16;              // quotient bits produced by the divider
    localparam int STEP_W    = $clog2(QUO_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_OUT
    } tsn_state_t;

endpackage

// File: sv/tsn_topk.sv
// ranked list of the kept scores and classes with running sum and class counter
module tsn_topk #(
    parameter int CLASS_COUNT_MAX = 16,
    parameter int KEEP_COUNT      = 4,
    parameter int IDX_W           = 2,
    parameter int SUM_W           = 17
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ins_en,
    input  logic [15:0]                  raw_score,
    input  logic                         clr,
    input  logic [IDX_W-1:0]             rd_idx,
    output logic [tsn_pkg::SCORE_W-1:0]  rd_score,
    output logic [tsn_pkg::CLASS_W-1:0]  rd_class,
    output logic [SUM_W-1:0]             sum
);
    import tsn_pkg::*;

    localparam int CNT_W = $clog2(CLASS_COUNT_MAX + 1);

    logic [SCORE_W-1:0] score_reg [KEEP_COUNT];
    logic [SCORE_W-1:0] score_next [KEEP_COUNT];
    logic [CLASS_W-1:0] class_reg [KEEP_COUNT];
    logic [CLASS_W-1:0] class_next [KEEP_COUNT];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEEP_COUNT-1:0] gt;
    logic [SCORE_W-1:0] value;
    logic [CLASS_W-1:0] cur_class;
    logic [CNT_W+CLASS_W-1:0] cnt_wide;
    logic               in_range;
    logic               positive;

    assign value     = raw_score[SCORE_W-1:0];
    assign positive  = !raw_score[15] && (raw_score != 16'd0);
    assign in_range  = cnt_reg < CNT_W'(CLASS_COUNT_MAX);
    assign cnt_wide  = {{CLASS_W{1'b0}}, cnt_reg};
    assign cur_class = cnt_wide[CLASS_W-1:0];

    // descending list, so the strictly-greater flags form a thermometer
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            gt[i] = value > score_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            score_next[i] = score_reg[i];
            class_next[i] = class_reg[i];
        end
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (clr) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                score_next[i] = '0;
                class_next[i] = '0;
            end
            sum_next = '0;
            cnt_next = '0;
        end else if (ins_en && in_range) begin
            cnt_next = cnt_reg + 1'b1;
            if (positive) begin
                if (gt[0]) begin
                    score_next[0] = value;
                    class_next[0] = cur_class;
                end
                for (int i = 1; i < KEEP_COUNT; i++) begin
                    if (gt[i]) begin
                        if (!gt[i-1]) begin
                            score_next[i] = value;
                            class_next[i] = cur_class;
                        end else begin
                            score_next[i] = score_reg[i-1];
                            class_next[i] = class_reg[i-1];
                        end
                    end
                end
                // the bottom entry drops out whenever the new score gets in
                if (gt[KEEP_COUNT-1]) begin
                    sum_next = sum_reg + SUM_W'(value) - SUM_W'(score_reg[KEEP_COUNT-1]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                score_reg[i] <= '0;
                class_reg[i] <= '0;
            end
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                score_reg[i] <= score_next[i];
                class_reg[i] <= class_next[i];
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    assign rd_score = score_reg[rd_idx];
    assign rd_class = class_reg[rd_idx];
    assign sum      = sum_reg;

endmodule

// File: sv/tsn_div.sv
// restoring divider, one quotient bit per cycle
module tsn_div #(
    parameter int DEN_W = 17
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tsn_pkg::NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]             den,
    output logic                         done,
    output logic [tsn_pkg::QUO_W-1:0]    quo
);
    import tsn_pkg::*;

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [DEN_W+HI_W-1:0] hi_wide;

    // the quotient never exceeds 2^15, so the top bits alone stay below den
    assign hi_wide = {{DEN_W{1'b0}}, num[NUM_W-1:QUO_W]};
    assign trial   = {rem_reg, low_reg[QUO_W-1]};
    assign diff    = trial - {1'b0, den};
    assign fits    = trial >= {1'b0, den};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = hi_wide[DEN_W-1:0];
            low_next  = num[QUO_W-1:0];
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next  = {low_reg[QUO_W-2:0], 1'b0};
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/top4_score_select_normalize.sv
// top level: score intake, ranked list, shared divider and result sequencer
module top4_score_select_normalize #(
    parameter int CLASS_COUNT_MAX = 16,
    parameter int KEEP_COUNT      = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] score, signed q8.8
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] rank, [9:2] class_index, [25:10] weight, rest zero
    output logic        m_tlast
);
    // one signed q8.8 score per beat, in class order; scores of zero or below are skipped
    // and the four (KEEP_COUNT) highest are kept, the earlier class winning a tie.
    // an ordinary beat is taken whenever the block is idle, so back-to-back scores stream
    // at one per clock. the beat flagged with tlast is folded in like the others,
    // then the block stops taking beats and sends KEEP_COUNT result beats, rank 0
    // first, each with weight = score / sum of kept scores in unsigned q1.15,
    // rounded to nearest. each weight runs through one shared restoring divider
    // that yields a quotient bit per cycle; each rank passes through a start state, the
    // divide state (skipped when the sum is zero) and an output state that waits for m_tready.
    // with no positive score, rank 0 reports weight 1.0 and the rest weight 0,
    // all with class 0. after the final rank is taken the list is cleared and
    // s_tready rises again. scores arriving past CLASS_COUNT_MAX are ignored.
    import tsn_pkg::*;

    localparam int IDX_W  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int SUM_W  = SCORE_W + $clog2(KEEP_COUNT);
    localparam int WIDE_W = NUM_W + SUM_W;

    tsn_state_t state_reg, state_next;

    logic [IDX_W-1:0]    rank_reg, rank_next;
    logic [CLASS_W-1:0]  class_reg, class_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;

    logic                in_beat;
    logic                out_beat;
    logic                final_rank;
    logic                sum_zero;
    logic                clr;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;
    logic [SCORE_W-1:0]  rd_score;
    logic [CLASS_W-1:0]  rd_class;
    logic [SUM_W-1:0]    sum;
    logic [WIDE_W-1:0]   num_wide;
    logic [IDX_W+RANK_W-1:0] rank_wide;

    assign in_beat    = s_tvalid && s_tready;
    assign out_beat   = m_tvalid && m_tready;
    assign final_rank = rank_reg == IDX_W'(KEEP_COUNT - 1);
    assign sum_zero   = sum == '0;

    // score * 2^15 plus half the sum, for round-to-nearest
    assign num_wide = ({{(WIDE_W-SCORE_W){1'b0}}, rd_score} << (WEIGHT_W - 1))
                    + {{(NUM_W+1){1'b0}}, sum[SUM_W-1:1]};

    tsn_topk #(
        .CLASS_COUNT_MAX (CLASS_COUNT_MAX),
        .KEEP_COUNT      (KEEP_COUNT),
        .IDX_W           (IDX_W),
        .SUM_W           (SUM_W)
    ) u_topk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ins_en    (in_beat),
        .raw_score (s_tdata),
        .clr       (clr),
        .rd_idx    (rank_reg),
        .rd_score  (rd_score),
        .rd_class  (rd_class),
        .sum       (sum)
    );

    tsn_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_wide[NUM_W-1:0]),
        .den     (sum),
        .done    (div_done),
        .quo     (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = sum_zero ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = final_rank ? ST_IDLE : ST_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        clr       = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_START: div_start = !sum_zero;
            ST_DIV:   ;
            ST_OUT: begin
                m_tvalid = 1'b1;
                clr      = m_tready && final_rank;
            end
            default:  ;
        endcase
    end

    // result register and rank counter
    always_comb begin
        rank_next   = rank_reg;
        class_next  = class_reg;
        weight_next = weight_reg;
        if (state_reg == ST_START && sum_zero) begin
            class_next  = '0;
            weight_next = (rank_reg == '0) ? WEIGHT_W'(1 << (WEIGHT_W - 1)) : '0;
        end else if (state_reg == ST_DIV && div_done) begin
            class_next  = rd_class;
            weight_next = div_quo;
        end
        if (out_beat) begin
            rank_next = final_rank ? '0 : rank_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        class_reg  <= class_next;
        weight_reg <= weight_next;
    end

    assign rank_wide = {{RANK_W{1'b0}}, rank_reg};
    assign m_tdata   = {6'd0, weight_reg, class_reg, rank_wide[RANK_W-1:0]};
    assign m_tlast   = final_rank;

endmodule
